### rtl/core/rnft_pkg.sv
// ----------------------------------------------------------------------------
// rnft_pkg
// Types, register codes and reset values shared by the noise floor threshold
// unit.
// ----------------------------------------------------------------------------
package rnft_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEAR_WINDOW      = 3'd0,
      CSR_FAR_WINDOW       = 3'd1,
      CSR_SAMPLES_NEEDED   = 3'd2,
      CSR_AVERAGE_LOW      = 3'd3,
      CSR_AVERAGE_HIGH     = 3'd4,
      CSR_THRESHOLD_OFFSET = 3'd5,
      CSR_MIN_RECAL_MS     = 3'd6,
      CSR_ATTEMPT_LIMIT    = 3'd7
   } csr_index_type;

   localparam logic [7:0]  NEAR_WINDOW_RST      = 8'd8;
   localparam logic [7:0]  FAR_WINDOW_RST       = 8'd50;
   localparam logic [7:0]  SAMPLES_NEEDED_RST   = 8'd20;
   localparam logic [7:0]  AVERAGE_LOW_RST      = 8'd10;
   localparam logic [7:0]  AVERAGE_HIGH_RST     = 8'd220;
   localparam logic [7:0]  THRESHOLD_OFFSET_RST = 8'd20;
   localparam logic [31:0] MIN_RECAL_MS_RST     = 32'd420000;
   localparam logic [9:0]  ATTEMPT_LIMIT_RST    = 10'd600;

   localparam logic [7:0]  THRESHOLD_RST  = 8'd160;
   localparam logic [2:0]  HITS_TO_RESEED = 3'd4;

   typedef struct packed {
      logic [7:0]  near_window;
      logic [7:0]  far_window;
      logic [7:0]  samples_needed;
      logic [7:0]  average_low;
      logic [7:0]  average_high;
      logic [7:0]  threshold_offset;
      logic [31:0] min_recal_interval_ms;
      logic [9:0]  attempt_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] busy_threshold;
      logic       threshold_updated;
      logic       finished;
      logic       fault;
   } result_type;

endpackage

### rtl/core/rnft_if.sv
// ----------------------------------------------------------------------------
// rnft_req_if / rnft_rsp_if
// Valid/ready channels for samples in and threshold results out.
// ----------------------------------------------------------------------------
interface rnft_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rssi;
   logic [31:0] now_ms;

   modport source (output valid, output rssi, output now_ms, input ready);
   modport sink   (input valid, input rssi, input now_ms, output ready);
endinterface

interface rnft_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] busy_threshold;
   logic       threshold_updated;
   logic       finished;
   logic       fault;

   modport source (output valid, output busy_threshold, output threshold_updated,
                   output finished, output fault, input ready);
   modport sink   (input valid, input busy_threshold, input threshold_updated,
                   input finished, input fault, output ready);
endinterface

### rtl/core/rnft_csr.sv
// ----------------------------------------------------------------------------
// rnft_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rnft_csr
   import rnft_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NEAR_WINDOW:      cfg_in.near_window      = csr_wdata[7:0];
            CSR_FAR_WINDOW:       cfg_in.far_window       = csr_wdata[7:0];
            CSR_SAMPLES_NEEDED:   cfg_in.samples_needed   = csr_wdata[7:0];
            CSR_AVERAGE_LOW:      cfg_in.average_low      = csr_wdata[7:0];
            CSR_AVERAGE_HIGH:     cfg_in.average_high     = csr_wdata[7:0];
            CSR_THRESHOLD_OFFSET: cfg_in.threshold_offset = csr_wdata[7:0];
            CSR_MIN_RECAL_MS:     cfg_in.min_recal_interval_ms = csr_wdata[31:0];
            CSR_ATTEMPT_LIMIT:    cfg_in.attempt_limit    = csr_wdata[9:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_window           <= NEAR_WINDOW_RST;
         cfg_ff.far_window            <= FAR_WINDOW_RST;
         cfg_ff.samples_needed        <= SAMPLES_NEEDED_RST;
         cfg_ff.average_low           <= AVERAGE_LOW_RST;
         cfg_ff.average_high          <= AVERAGE_HIGH_RST;
         cfg_ff.threshold_offset      <= THRESHOLD_OFFSET_RST;
         cfg_ff.min_recal_interval_ms <= MIN_RECAL_MS_RST;
         cfg_ff.attempt_limit         <= ATTEMPT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/rnft_calc.sv
// ----------------------------------------------------------------------------
// rnft_calc
// Estimator state and the single-pass update for one sample.
// ----------------------------------------------------------------------------
module rnft_calc
   import rnft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        step,
   input  logic [7:0]  rssi,
   input  logic [31:0] now_ms,
   output result_type  result
);

   logic [7:0]  noise_average_ff,  noise_average_in;
   logic [7:0]  outlier_cand_ff,   outlier_cand_in;
   logic [2:0]  cand_hits_ff,      cand_hits_in;
   logic [7:0]  agree_count_ff,    agree_count_in;
   logic [9:0]  attempt_timer_ff,  attempt_timer_in;
   logic [31:0] last_cal_ms_ff,    last_cal_ms_in;
   logic [7:0]  threshold_ff,      threshold_in;

   logic [7:0]  diff_avg;
   logic [7:0]  diff_cand;
   logic [31:0] interval_ms;
   logic [7:0]  folded_avg;
   logic [7:0]  agree_inc;
   logic [2:0]  hits_inc;
   logic [8:0]  thresh_sum;
   logic [10:0] timer_inc;
   logic        near_hit;
   logic        far_hit;
   logic        done;
   logic        range_bad;
   logic        too_early;
   logic        updated;
   logic        finished;
   logic        fault;

   assign diff_avg    = (rssi > noise_average_ff) ? rssi - noise_average_ff
                                                  : noise_average_ff - rssi;
   assign diff_cand   = (rssi > outlier_cand_ff) ? rssi - outlier_cand_ff
                                                 : outlier_cand_ff - rssi;
   assign interval_ms = (last_cal_ms_ff > now_ms) ? last_cal_ms_ff - now_ms
                                                  : now_ms - last_cal_ms_ff;
   assign near_hit    = diff_avg < cfg.near_window;
   assign far_hit     = diff_cand < cfg.far_window;
   assign folded_avg  = {1'b0, noise_average_ff[7:1]} + {1'b0, rssi[7:1]};
   assign agree_inc   = agree_count_ff + 8'd1;
   assign hits_inc    = cand_hits_ff + 3'd1;
   assign done        = near_hit && (agree_inc > cfg.samples_needed);
   assign range_bad   = (folded_avg < cfg.average_low) || (folded_avg > cfg.average_high);
   assign thresh_sum  = {1'b0, folded_avg} + {1'b0, cfg.threshold_offset};
   assign too_early   = (last_cal_ms_ff != 32'd0) && (interval_ms < cfg.min_recal_interval_ms);
   assign timer_inc   = {1'b0, attempt_timer_ff} + 11'd1;

   always_comb begin
      noise_average_in = noise_average_ff;
      outlier_cand_in  = outlier_cand_ff;
      cand_hits_in     = cand_hits_ff;
      agree_count_in   = agree_count_ff;
      attempt_timer_in = attempt_timer_ff;
      last_cal_ms_in   = last_cal_ms_ff;
      threshold_in     = threshold_ff;
      updated          = 1'b0;
      finished         = 1'b0;
      fault            = 1'b0;

      if (near_hit) begin
         noise_average_in = folded_avg;
         agree_count_in   = agree_inc;
         if (done) begin
            finished         = 1'b1;
            attempt_timer_in = 10'd0;
            if (range_bad) begin
               fault = 1'b1;
            end else begin
               threshold_in = thresh_sum[8] ? 8'hff : thresh_sum[7:0];
               updated      = 1'b1;
               if (too_early) begin
                  fault          = 1'b1;
                  last_cal_ms_in = 32'd0;
               end else begin
                  last_cal_ms_in = now_ms;
               end
            end
         end
      end else if (far_hit) begin
         cand_hits_in = hits_inc;
         // persistent outlier takes over the average
         if (hits_inc > HITS_TO_RESEED) begin
            noise_average_in = rssi;
            agree_count_in   = 8'd0;
            cand_hits_in     = 3'd0;
         end
      end else begin
         outlier_cand_in = rssi;
         cand_hits_in    = 3'd0;
      end

      if (!done) begin
         if (timer_inc > {1'b0, cfg.attempt_limit}) begin
            attempt_timer_in = 10'd0;
            fault            = 1'b1;
            finished         = 1'b1;
         end else begin
            attempt_timer_in = timer_inc[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_average_ff <= 8'd0;
         outlier_cand_ff  <= 8'd0;
         cand_hits_ff     <= 3'd0;
         agree_count_ff   <= 8'd0;
         attempt_timer_ff <= 10'd0;
         last_cal_ms_ff   <= 32'd0;
         threshold_ff     <= THRESHOLD_RST;
      end else if (step) begin
         noise_average_ff <= noise_average_in;
         outlier_cand_ff  <= outlier_cand_in;
         cand_hits_ff     <= cand_hits_in;
         agree_count_ff   <= agree_count_in;
         attempt_timer_ff <= attempt_timer_in;
         last_cal_ms_ff   <= last_cal_ms_in;
         threshold_ff     <= threshold_in;
      end
   end

   assign result.busy_threshold    = threshold_in;
   assign result.threshold_updated = updated;
   assign result.finished          = finished;
   assign result.fault             = fault;

endmodule

### rtl/core/rssi_noise_floor_threshold_unit.sv
// ----------------------------------------------------------------------------
// rssi_noise_floor_threshold_unit
// Noise floor estimator and channel busy threshold for raw RSSI samples.
// ----------------------------------------------------------------------------
// One result per sample, valid from the output register after the sample is
// accepted, and a new sample is accepted every cycle while results are taken.
// A sample is held in an input register, the estimator state is updated from
// it in one pass of compare/add logic, and the result lands in an output
// register; a full output register stalls the input register, which stalls
// req_chan.ready.
// Configuration writes take effect on the next cycle and should be made while
// no samples are in flight.
module rssi_noise_floor_threshold_unit
   import rnft_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rnft_req_if.sink               req_chan,
   rnft_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg;
   result_type  calc_result;
   result_type  result_ff;
   logic        rsp_valid_ff;
   logic        in_valid_ff;
   logic [7:0]  rssi_ff;
   logic [31:0] now_ms_ff;
   logic        out_free;
   logic        in_free;
   logic        step;

   rnft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rnft_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .rssi   (rssi_ff),
      .now_ms (now_ms_ff),
      .result (calc_result)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign in_free        = !in_valid_ff || out_free;
   assign req_chan.ready = in_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_chan.valid) begin
         rssi_ff   <= req_chan.rssi;
         now_ms_ff <= req_chan.now_ms;
      end
      if (step) begin
         result_ff <= calc_result;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.busy_threshold    = result_ff.busy_threshold;
   assign rsp_chan.threshold_updated = result_ff.threshold_updated;
   assign rsp_chan.finished          = result_ff.finished;
   assign rsp_chan.fault             = result_ff.fault;

endmodule
